### hdl/fsdplc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdplc_pkg
// Shared types, constants and helpers of the pyramid level convert unit.
// ----------------------------------------------------------------------------
package fsdplc_pkg;

  localparam int HALF_TAPS_DEF = 2;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MIN_DIM       = 4;

  localparam int PIX_W    = 16;
  localparam int SMOOTH_W = 20;
  localparam int COEF_W   = 16;
  localparam int GEO_W    = 11;
  localparam int ROW_W    = 10;
  localparam int PROD_W   = 36;
  localparam int ACC_W    = 42;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RECIP_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MODE_ADD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_SIDE3   = 3'd6;

  localparam logic [GEO_W-1:0]  WIDTH_RST  = 11'd512;
  localparam logic [GEO_W-1:0]  HEIGHT_RST = 11'd512;
  localparam logic [COEF_W-1:0] COEF0_RST  = 16'd12288;
  localparam logic [COEF_W-1:0] COEF1_RST  = 16'd8192;
  localparam logic [COEF_W-1:0] COEF2_RST  = 16'd2048;
  localparam logic [COEF_W-1:0] COEF3_RST  = 16'd0;

  typedef struct packed {
    logic latch_in;
    logic wr_orig;
    logic h_init;
    logic rd_vorig;
    logic mul;
    logic mul_v;
    logic acc_add;
    logic h_store;
    logic adv_in;
    logic cap_orig;
    logic out_load;
    logic adv_out;
  } cmd_t;

  typedef struct packed {
    logic pixel_ok;
    logic h_any;
    logic tap_last;
    logic h_last;
    logic out_due;
  } status_t;

  // row modulo a small ring size, by reciprocal multiply
  function automatic logic [2:0] row_slot(input logic [ROW_W-1:0] row,
                                          input logic [16:0] recip,
                                          input logic [2:0] m);
    logic [ROW_W+16:0] prod;
    logic [ROW_W-1:0]  q;
    logic [ROW_W+2:0]  qm;
    logic [ROW_W+2:0]  diff;
    prod = (ROW_W+17)'(row) * (ROW_W+17)'(recip);
    q    = prod[ROW_W+RECIP_SHIFT-1:RECIP_SHIFT];
    qm   = (ROW_W+3)'(q) * (ROW_W+3)'(m);
    diff = (ROW_W+3)'(row) - qm;
    return diff[2:0];
  endfunction

endpackage

### hdl/fsd_pyramid_level_convert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsd_pyramid_level_convert_unit
// Laplacian/Burt conversion of one pyramid level with a separable kernel.
// ----------------------------------------------------------------------------
// One item at a time. A pixel is written and counted; the horizontal taps run
// in turn for each output column it completes (none for the first HALF_TAPS
// pixels of a row, else one, or HALF_TAPS+1 at the end of a row), since the
// taps share one multiplier and one read port of the pixel line store. An
// item that releases a result then runs the vertical taps over the smoothed
// line store. Results leave HALF_TAPS rows plus HALF_TAPS pixels behind the
// input; drain items flush the tail. Writing width or height restarts the frame.
module fsd_pyramid_level_convert_unit #(
  parameter int HALF_TAPS = fsdplc_pkg::HALF_TAPS_DEF,
  parameter int MAX_WIDTH = fsdplc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fsdplc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fsdplc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [fsdplc_pkg::PIX_W-1:0] in_pixel,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fsdplc_pkg::PIX_W-1:0] out_result_pixel,
  output logic                                out_frame_last
);

  fsdplc_pkg::cmd_t    cmd;
  fsdplc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  fsdplc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fsdplc_dp #(.HALF_TAPS(HALF_TAPS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_kind          (in_kind),
    .in_pixel         (in_pixel),
    .cmd              (cmd),
    .status           (status),
    .out_result_pixel (out_result_pixel),
    .out_frame_last   (out_frame_last)
  );

endmodule

### hdl/fsdplc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdplc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsdplc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/fsdplc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdplc_ctrl
// Sequencer: pixel write, horizontal taps, vertical taps, result load.
// ----------------------------------------------------------------------------
module fsdplc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fsdplc_pkg::status_t status,
  output fsdplc_pkg::cmd_t    cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_WR    = 14'b00000000000010,
    S_HADDR = 14'b00000000000100,
    S_HMUL  = 14'b00000000001000,
    S_HACC  = 14'b00000000010000,
    S_HST   = 14'b00000000100000,
    S_ADV   = 14'b00000001000000,
    S_CHK   = 14'b00000010000000,
    S_VORIG = 14'b00000100000000,
    S_VCAP  = 14'b00001000000000,
    S_VADDR = 14'b00010000000000,
    S_VMUL  = 14'b00100000000000,
    S_VACC  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = status.pixel_ok ? S_WR : S_CHK;
        end
      end
      S_WR: begin
        cmd.wr_orig = 1'b1;
        cmd.h_init  = 1'b1;
        state_nxt   = status.h_any ? S_HADDR : S_ADV;
      end
      S_HADDR: state_nxt = S_HMUL;
      S_HMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_HACC;
      end
      S_HACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = status.tap_last ? S_HST : S_HADDR;
      end
      S_HST: begin
        cmd.h_store = 1'b1;
        state_nxt   = status.h_last ? S_ADV : S_HADDR;
      end
      S_ADV: begin
        cmd.adv_in = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: state_nxt = status.out_due ? S_VORIG : S_IDLE;
      S_VORIG: begin
        cmd.rd_vorig = 1'b1;
        state_nxt    = S_VCAP;
      end
      S_VCAP: begin
        cmd.cap_orig = 1'b1;
        state_nxt    = S_VADDR;
      end
      S_VADDR: state_nxt = S_VMUL;
      S_VMUL: begin
        cmd.mul   = 1'b1;
        cmd.mul_v = 1'b1;
        state_nxt = S_VACC;
      end
      S_VACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = status.tap_last ? S_OUT : S_VADDR;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.adv_out  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/fsdplc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsdplc_dp
// Datapath: registers, line stores, shared tap multiplier and counters.
// ----------------------------------------------------------------------------
module fsdplc_dp #(
  parameter int HALF_TAPS = fsdplc_pkg::HALF_TAPS_DEF,
  parameter int MAX_WIDTH = fsdplc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr,
  input  logic [fsdplc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fsdplc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                   in_kind,
  input  logic signed [fsdplc_pkg::PIX_W-1:0]    in_pixel,
  input  fsdplc_pkg::cmd_t                       cmd,
  output fsdplc_pkg::status_t                    status,
  output logic signed [fsdplc_pkg::PIX_W-1:0]    out_result_pixel,
  output logic                                   out_frame_last
);

  localparam int ORIG_ROWS   = HALF_TAPS + 1;
  localparam int SMOOTH_ROWS = 2 * HALF_TAPS + 1;
  localparam int TAPS        = 2 * HALF_TAPS + 1;
  localparam int TW          = $clog2(TAPS);
  localparam int CLW         = $clog2(MAX_WIDTH);
  localparam int WW          = $clog2(MAX_WIDTH + 1);
  localparam int GW          = fsdplc_pkg::GEO_W;
  localparam int RW          = fsdplc_pkg::ROW_W;
  localparam int MW          = (WW > GW) ? WW : GW;
  localparam int IW          = MW + 2;
  localparam int TOT_W       = WW + GW;
  localparam int O_DEPTH     = ORIG_ROWS * MAX_WIDTH;
  localparam int S_DEPTH     = SMOOTH_ROWS * MAX_WIDTH;
  localparam int OAW         = $clog2(O_DEPTH);
  localparam int SAW         = $clog2(S_DEPTH);
  localparam int O_RECIP     = (65536 + ORIG_ROWS - 1) / ORIG_ROWS;
  localparam int S_RECIP     = (65536 + SMOOTH_ROWS - 1) / SMOOTH_ROWS;
  localparam int PW          = fsdplc_pkg::PIX_W;
  localparam int SW          = fsdplc_pkg::SMOOTH_W;
  localparam int CW          = fsdplc_pkg::COEF_W;
  localparam int AW          = fsdplc_pkg::ACC_W;
  localparam int PRW         = fsdplc_pkg::PROD_W;

  // configuration
  logic                 mode_r;
  logic [GW-1:0]        wcfg_r, hcfg_r;
  logic signed [CW-1:0] coef_r [4];
  logic [WW-1:0]        eff_w_r, eff_w_nxt;
  logic [GW-1:0]        eff_h_r, eff_h_nxt;
  logic [TOT_W-1:0]     total_r, delay_r;
  logic                 cfg_restart;

  // counters
  logic [CLW-1:0]   in_col_r, h_col_r, h_end_r, out_col_r;
  logic [RW-1:0]    in_row_r, out_row_r;
  logic             in_done_r;
  logic [TOT_W-1:0] in_count_r, out_count_r;
  logic [TW-1:0]    tap_r;

  // arithmetic
  logic signed [PW-1:0]  pixel_r, orig_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [AW-1:0]  acc_r;
  logic signed [PW-1:0]  res_r;
  logic                  last_r;

  always_comb begin
    if (MW'(wcfg_r) < MW'(fsdplc_pkg::MIN_DIM)) begin
      eff_w_nxt = WW'(fsdplc_pkg::MIN_DIM);
    end else if (MW'(wcfg_r) > MW'(MAX_WIDTH)) begin
      eff_w_nxt = WW'(MAX_WIDTH);
    end else begin
      eff_w_nxt = WW'(wcfg_r);
    end
    if (hcfg_r < GW'(fsdplc_pkg::MIN_DIM)) begin
      eff_h_nxt = GW'(fsdplc_pkg::MIN_DIM);
    end else if (hcfg_r > GW'(fsdplc_pkg::MAX_HEIGHT)) begin
      eff_h_nxt = GW'(fsdplc_pkg::MAX_HEIGHT);
    end else begin
      eff_h_nxt = hcfg_r;
    end
  end

  assign cfg_restart = cfg_wr && (cfg_index == fsdplc_pkg::REG_IMAGE_WIDTH ||
                                  cfg_index == fsdplc_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      wcfg_r    <= fsdplc_pkg::WIDTH_RST;
      hcfg_r    <= fsdplc_pkg::HEIGHT_RST;
      coef_r[0] <= fsdplc_pkg::COEF0_RST;
      coef_r[1] <= fsdplc_pkg::COEF1_RST;
      coef_r[2] <= fsdplc_pkg::COEF2_RST;
      coef_r[3] <= fsdplc_pkg::COEF3_RST;
      eff_w_r   <= WW'(fsdplc_pkg::WIDTH_RST);
      eff_h_r   <= fsdplc_pkg::HEIGHT_RST;
      total_r   <= '0;
      delay_r   <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      total_r <= TOT_W'(eff_w_r) * TOT_W'(eff_h_r);
      delay_r <= TOT_W'(eff_w_r) * TOT_W'(HALF_TAPS) + TOT_W'(HALF_TAPS);
      if (cfg_wr) begin
        case (cfg_index)
          fsdplc_pkg::REG_MODE_ADD:     mode_r    <= cfg_data[0];
          fsdplc_pkg::REG_IMAGE_WIDTH:  wcfg_r    <= cfg_data[GW-1:0];
          fsdplc_pkg::REG_IMAGE_HEIGHT: hcfg_r    <= cfg_data[GW-1:0];
          fsdplc_pkg::REG_COEF_CENTER:  coef_r[0] <= cfg_data;
          fsdplc_pkg::REG_COEF_SIDE1:   coef_r[1] <= cfg_data;
          fsdplc_pkg::REG_COEF_SIDE2:   coef_r[2] <= cfg_data;
          fsdplc_pkg::REG_COEF_SIDE3:   coef_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // mirrored index: -n maps to n, last+n maps to last-n
  function automatic logic [MW-1:0] mirror(input logic signed [IW-1:0] i,
                                           input logic [MW-1:0] n);
    logic signed [IW-1:0] last;
    logic signed [IW-1:0] v;
    last = $signed(IW'(n)) - IW'(1);
    v    = i;
    if (v < 0) begin
      v = -v;
    end
    if (v > last) begin
      v = (last <<< 1) - v;
    end
    return v[MW-1:0];
  endfunction

  // tap offset and its distance from center
  logic signed [IW-1:0] koff;
  logic [1:0]           kabs;
  logic signed [CW-1:0] coef_sel;

  assign koff     = $signed(IW'(tap_r)) - IW'(HALF_TAPS);
  assign kabs     = (koff < 0) ? 2'((-koff)) : 2'(koff);
  assign coef_sel = coef_r[kabs];

  // slots in the row rings
  logic [2:0] oslot_in, sslot_in, oslot_out, sslot_v;
  logic [MW-1:0] h_idx, v_row;

  assign h_idx = mirror($signed(IW'(h_col_r)) + koff, MW'(eff_w_r));
  assign v_row = mirror($signed(IW'(out_row_r)) + koff, MW'(eff_h_r));

  assign oslot_in  = fsdplc_pkg::row_slot(in_row_r, 17'(O_RECIP), 3'(ORIG_ROWS));
  assign sslot_in  = fsdplc_pkg::row_slot(in_row_r, 17'(S_RECIP), 3'(SMOOTH_ROWS));
  assign oslot_out = fsdplc_pkg::row_slot(out_row_r, 17'(O_RECIP), 3'(ORIG_ROWS));
  assign sslot_v   = fsdplc_pkg::row_slot(v_row[RW-1:0], 17'(S_RECIP), 3'(SMOOTH_ROWS));

  logic [OAW-1:0] o_waddr, o_raddr;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [PW-1:0]  o_rdata;
  logic [SW-1:0]  s_rdata, s_wdata;

  assign o_waddr = OAW'(oslot_in) * OAW'(MAX_WIDTH) + OAW'(in_col_r);
  assign o_raddr = cmd.rd_vorig ? OAW'(oslot_out) * OAW'(MAX_WIDTH) + OAW'(out_col_r)
                                : OAW'(oslot_in) * OAW'(MAX_WIDTH) + OAW'(h_idx);
  assign s_waddr = SAW'(sslot_in) * SAW'(MAX_WIDTH) + SAW'(h_col_r);
  assign s_raddr = SAW'(sslot_v) * SAW'(MAX_WIDTH) + SAW'(out_col_r);

  fsdplc_ram #(.WIDTH(PW), .DEPTH(O_DEPTH)) u_orig_ram (
    .clk   (clk),
    .we    (cmd.wr_orig),
    .waddr (o_waddr),
    .wdata (pixel_r),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  fsdplc_ram #(.WIDTH(SW), .DEPTH(S_DEPTH)) u_smooth_ram (
    .clk   (clk),
    .we    (cmd.h_store),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // horizontal result: round to Q.4 and saturate to 20 bits
  logic signed [AW-1:0] h_round;
  always_comb begin
    h_round = (acc_r + AW'(1024)) >>> 11;
    if (h_round > AW'(524287)) begin
      s_wdata = SW'(524287);
    end else if (h_round < -AW'(524288)) begin
      s_wdata = SW'(-524288);
    end else begin
      s_wdata = h_round[SW-1:0];
    end
  end

  // final result
  logic signed [AW-1:0] base, res_sum, res_sh;
  logic signed [PW-1:0] res_nxt;
  always_comb begin
    base    = AW'(orig_r) <<< 19;
    res_sum = mode_r ? base + acc_r : base - acc_r;
    res_sh  = (res_sum + AW'(262144)) >>> 19;
    if (res_sh > AW'(32767)) begin
      res_nxt = 16'sh7fff;
    end else if (res_sh < -AW'(32768)) begin
      res_nxt = 16'sh8000;
    end else begin
      res_nxt = res_sh[PW-1:0];
    end
  end

  logic signed [SW-1:0] mul_op;
  assign mul_op = cmd.mul_v ? $signed(s_rdata) : SW'($signed(o_rdata));

  // status
  logic in_col_last, in_row_last, out_col_last, out_row_last, out_end;
  logic [TOT_W:0] due_lim;

  assign in_col_last  = WW'(in_col_r) == eff_w_r - WW'(1);
  assign in_row_last  = GW'(in_row_r) == eff_h_r - GW'(1);
  assign out_col_last = WW'(out_col_r) == eff_w_r - WW'(1);
  assign out_row_last = GW'(out_row_r) == eff_h_r - GW'(1);
  assign out_end      = (out_count_r + TOT_W'(1)) >= total_r;
  assign due_lim      = (TOT_W+1)'(out_count_r) + (TOT_W+1)'(delay_r) + (TOT_W+1)'(1);

  assign status.pixel_ok = !in_kind && !in_done_r;
  assign status.h_any    = (in_col_r >= CLW'(HALF_TAPS)) || in_col_last;
  assign status.tap_last = tap_r == TW'(TAPS - 1);
  assign status.h_last   = h_col_r == h_end_r;
  assign status.out_due  = (out_count_r < total_r) &&
                           (in_done_r || (TOT_W+1)'(in_count_r) >= due_lim);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pixel_r <= in_pixel;
    end
    if (cmd.mul) begin
      prod_r <= PRW'(coef_sel) * PRW'(mul_op);
    end
    if (cmd.cap_orig) begin
      orig_r <= $signed(o_rdata);
    end
    if (cmd.out_load) begin
      res_r  <= res_nxt;
      last_r <= out_count_r == total_r - TOT_W'(1);
    end
    if (cmd.h_init) begin
      h_col_r <= (in_col_r >= CLW'(HALF_TAPS)) ? in_col_r - CLW'(HALF_TAPS)
                                               : CLW'(eff_w_r - WW'(HALF_TAPS));
      h_end_r <= in_col_last ? in_col_r : in_col_r - CLW'(HALF_TAPS);
    end else if (cmd.h_store) begin
      h_col_r <= h_col_r + CLW'(1);
    end
    if (cmd.h_init || cmd.h_store || cmd.cap_orig) begin
      tap_r <= '0;
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      tap_r <= tap_r + TW'(1);
      acc_r <= acc_r + AW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_done_r   <= 1'b0;
      in_count_r  <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_count_r <= '0;
    end else if (cfg_restart || (cmd.adv_out && out_end)) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_done_r   <= 1'b0;
      in_count_r  <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_count_r <= '0;
    end else begin
      if (cmd.adv_in) begin
        in_count_r <= in_count_r + TOT_W'(1);
        if (in_col_last) begin
          in_col_r <= '0;
          if (in_row_last) begin
            in_row_r  <= '0;
            in_done_r <= 1'b1;
          end else begin
            in_row_r <= in_row_r + RW'(1);
          end
        end else begin
          in_col_r <= in_col_r + CLW'(1);
        end
      end
      if (cmd.adv_out) begin
        out_count_r <= out_count_r + TOT_W'(1);
        if (out_col_last) begin
          out_col_r <= '0;
          if (!out_row_last) begin
            out_row_r <= out_row_r + RW'(1);
          end
        end else begin
          out_col_r <= out_col_r + CLW'(1);
        end
      end
    end
  end

  assign out_result_pixel = res_r;
  assign out_frame_last   = last_r;

`ifndef ASSERT_OFF
  a_out_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_count_r <= total_r || $past(cfg_wr) || $past(cfg_wr, 2))
    else $error("result count ran past frame size");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < eff_w_r || $past(cfg_wr))
    else $error("input column beyond row width");

  a_in_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    !in_done_r |-> in_count_r >= out_count_r)
    else $error("result issued before its input arrived");
`endif

endmodule
